[src/fbbp_pkg.sv]
// shared types, constants and helpers of the fixed block buffer pool
package fbbp_pkg;

  // built depth of the free list and of the reservation marks
  localparam int MAX_BLOCKS  = 256;
  localparam int IDX_W       = $clog2(MAX_BLOCKS);
  localparam int CNT_W       = $clog2(MAX_BLOCKS + 1);

  // field and register widths
  localparam int ADDR_W      = 32;
  localparam int SIZE_W      = 16;
  localparam int COUNT_W     = 9;
  localparam int OUT_IDX_W   = 8;
  localparam int OFF_W       = SIZE_W + IDX_W;
  localparam int CFG_IDX_W   = 2;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // divider step counter
  localparam int STEP_W      = $clog2(IDX_W + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd3;

  // request actions
  localparam logic ACT_ACQUIRE = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_DISABLED  = 2'd2,
    ST_ZERO_ADDR = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CMD_DISABLED = 3'd0,
    CMD_ZERO     = 3'd1,
    CMD_IGNORE   = 3'd2,
    CMD_ACQUIRE  = 3'd3,
    CMD_RELEASE  = 3'd4
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [OFF_W-1:0]   off;
  } cmd_t;

  typedef struct packed {
    logic               enable;
    logic [ADDR_W-1:0]  base;
    logic [SIZE_W-1:0]  size;
    logic [COUNT_W-1:0] count;
  } cfg_t;

  typedef struct packed {
    status_e              status;
    logic [ADDR_W-1:0]    addr;
    logic [OUT_IDX_W-1:0] index;
    logic                 was_reserved;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [OFF_W-1:0]  off;
    logic [SIZE_W-1:0] size;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] quot;
    logic             rem_zero;
  } div_rsp_t;

  // circular pointer advance over the built depth
  function automatic logic [IDX_W-1:0] ptr_next(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] r;
    if (p == IDX_W'(MAX_BLOCKS - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

[src/fbbp_front.sv]
// front end: request intake, classification and request queue
module fbbp_front import fbbp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              fill_busy_i,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [ADDR_W-1:0] s_axis_tdata_i,   // buffer_address
  input  logic [0:0]        s_axis_tuser_i,   // action
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output cmd_t              cmd_o
);

  cmd_t              q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push;
  logic              pop;
  logic [ADDR_W-1:0] off;
  logic [ADDR_W-1:0] limit;
  cmd_t              cmd_new;

  // classify the incoming request
  always_comb begin
    off           = s_axis_tdata_i - cfg_i.base;
    limit         = ADDR_W'(cfg_i.size) * ADDR_W'(MAX_BLOCKS);
    cmd_new.off   = OFF_W'(off);
    if (!cfg_i.enable) begin
      cmd_new.kind = CMD_DISABLED;
    end else if (s_axis_tuser_i[0] == ACT_ACQUIRE) begin
      cmd_new.kind = CMD_ACQUIRE;
    end else if (s_axis_tdata_i == '0) begin
      cmd_new.kind = CMD_ZERO;
    end else if (off < limit) begin
      cmd_new.kind = CMD_RELEASE;
    end else begin
      cmd_new.kind = CMD_IGNORE;
    end
  end

  // queue handshake
  assign s_axis_tready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH)) && !fill_busy_i;
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd_valid_o     = (cnt_q != '0);
  assign pop             = cmd_valid_o && cmd_ready_i;
  assign cmd_o           = q_mem[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_new;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[src/fbbp_div.sv]
// restoring divider, one quotient bit per cycle
module fbbp_div import fbbp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [OFF_W-1:0]  rem_q;
  logic [OFF_W-1:0]  dvs_q;
  logic [IDX_W-1:0]  quot_q;
  logic              fits;

  assign fits          = (rem_q >= dvs_q);
  assign rsp_o.done     = done_q;
  assign rsp_o.quot     = quot_q;
  assign rsp_o.rem_zero = (rem_q == '0);

  // iteration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      quot_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(IDX_W - 1);
        rem_q  <= req_i.off;
        dvs_q  <= OFF_W'(req_i.size) << (IDX_W - 1);
        quot_q <= '0;
      end else if (busy_q) begin
        if (fits) begin
          rem_q <= rem_q - dvs_q;
        end
        quot_q <= IDX_W'({quot_q, fits});
        dvs_q  <= dvs_q >> 1;
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

endmodule

[src/fbbp_back.sv]
// back end: free list, reservation marks, sequencer and result register
module fbbp_back import fbbp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    rebuild_i,
  input  logic    cmd_valid_i,
  output logic    cmd_ready_o,
  input  cmd_t    cmd_i,
  output logic    fill_busy_o,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_FILL = 6'b000010,
    S_READ = 6'b000100,
    S_ADD  = 6'b001000,
    S_DIV  = 6'b010000,
    S_MARK = 6'b100000
  } state_e;

  state_e                state_q;
  state_e                state_d;
  logic [IDX_W-1:0]      head_q;
  logic [IDX_W-1:0]      tail_q;
  logic [CNT_W-1:0]      count_q;
  logic [IDX_W-1:0]      fill_q;
  logic [IDX_W-1:0]      mem [MAX_BLOCKS];
  logic                  mark_mem [MAX_BLOCKS];
  logic [IDX_W-1:0]      rdata_q;
  logic                  mark_q;
  logic [IDX_W-1:0]      idx_q;
  logic [OFF_W-1:0]      prod_q;
  logic                  out_valid_q;
  result_t               out_q;

  logic                  pop;
  logic                  rd_en;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [IDX_W-1:0]      mem_wdata;
  logic                  mark_rd_en;
  logic                  mark_we;
  logic [IDX_W-1:0]      mark_waddr;
  logic                  mark_wdata;
  logic                  match;
  logic [CNT_W-1:0]      build_n;
  logic [IDX_W-1:0]      tail_init;
  div_req_t              div_req;
  div_rsp_t              div_rsp;

  function automatic result_t mk_res(input status_e s, input logic [ADDR_W-1:0] a,
                                     input logic [IDX_W-1:0] i, input logic w);
    result_t r;
    r.status       = s;
    r.addr         = a;
    r.index        = OUT_IDX_W'(i);
    r.was_reserved = w;
    return r;
  endfunction

  fbbp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // pool size at rebuild, saturated to the built depth
  always_comb begin
    if (ADDR_W'(cfg_i.count) > ADDR_W'(MAX_BLOCKS)) begin
      build_n = CNT_W'(MAX_BLOCKS);
    end else begin
      build_n = CNT_W'(cfg_i.count);
    end
    tail_init = (build_n == CNT_W'(MAX_BLOCKS)) ? '0 : IDX_W'(build_n);
  end

  assign match       = div_rsp.rem_zero && mark_q;
  assign cmd_ready_o = pop;
  assign fill_busy_o = (state_q == S_FILL);
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  // sequencer
  always_comb begin
    state_d       = state_q;
    pop           = 1'b0;
    rd_en         = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = fill_q;
    mem_wdata     = fill_q;
    mark_rd_en    = 1'b0;
    mark_we       = 1'b0;
    mark_waddr    = fill_q;
    mark_wdata    = 1'b0;
    div_req.start = 1'b0;
    div_req.off   = cmd_i.off;
    div_req.size  = cfg_i.size;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && !out_valid_q) begin
          pop = 1'b1;
          case (cmd_i.kind)
            CMD_ACQUIRE: begin
              if (count_q != '0) begin
                rd_en   = 1'b1;
                state_d = S_READ;
              end
            end
            CMD_RELEASE: begin
              div_req.start = 1'b1;
              state_d       = S_DIV;
            end
            default: ;
          endcase
        end
      end
      S_FILL: begin
        // load the free list and clear the mark, one entry per cycle
        mem_we  = 1'b1;
        mark_we = 1'b1;
        if (fill_q == IDX_W'(MAX_BLOCKS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        mark_we    = 1'b1;
        mark_waddr = rdata_q;
        mark_wdata = 1'b1;
        state_d    = S_ADD;
      end
      S_ADD:  state_d = S_IDLE;
      S_DIV: begin
        if (div_rsp.done) begin
          mark_rd_en = 1'b1;
          state_d    = S_MARK;
        end
      end
      S_MARK: begin
        state_d = S_IDLE;
        if (match) begin
          mem_we     = 1'b1;
          mem_waddr  = tail_q;
          mem_wdata  = div_rsp.quot;
          mark_we    = 1'b1;
          mark_waddr = div_rsp.quot;
          mark_wdata = 1'b0;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (rebuild_i) begin
      state_d = S_FILL;
    end
  end

  // free list memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[head_q];
    end
  end

  // reservation mark memory
  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    if (mark_rd_en) begin
      mark_q <= mark_mem[div_rsp.quot];
    end
  end

  // pool state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      fill_q      <= '0;
      idx_q       <= '0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && res_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (rebuild_i) begin
        head_q     <= '0;
        tail_q     <= tail_init;
        count_q    <= build_n;
        fill_q     <= '0;
      end else begin
        unique case (state_q)
          S_IDLE: begin
            if (pop) begin
              case (cmd_i.kind)
                CMD_DISABLED: begin
                  out_q       <= mk_res(ST_DISABLED, '0, '0, 1'b0);
                  out_valid_q <= 1'b1;
                end
                CMD_ZERO: begin
                  out_q       <= mk_res(ST_ZERO_ADDR, '0, '0, 1'b0);
                  out_valid_q <= 1'b1;
                end
                CMD_ACQUIRE: begin
                  if (count_q == '0) begin
                    out_q       <= mk_res(ST_EMPTY, '0, '0, 1'b0);
                    out_valid_q <= 1'b1;
                  end else begin
                    head_q  <= ptr_next(head_q);
                    count_q <= count_q - 1'b1;
                  end
                end
                CMD_RELEASE: ;
                default: begin
                  out_q       <= mk_res(ST_OK, '0, '0, 1'b0);
                  out_valid_q <= 1'b1;
                end
              endcase
            end
          end
          S_FILL: begin
            fill_q <= fill_q + 1'b1;
          end
          S_READ: begin
            idx_q  <= rdata_q;
            prod_q <= OFF_W'(rdata_q) * OFF_W'(cfg_i.size);
          end
          S_ADD: begin
            out_q       <= mk_res(ST_OK, cfg_i.base + ADDR_W'(prod_q), idx_q, 1'b0);
            out_valid_q <= 1'b1;
          end
          S_MARK: begin
            out_valid_q <= 1'b1;
            if (match) begin
              tail_q <= ptr_next(tail_q);
              if (count_q < CNT_W'(MAX_BLOCKS)) begin
                count_q <= count_q + 1'b1;
              end
              out_q <= mk_res(ST_OK, '0, div_rsp.quot, 1'b1);
            end else begin
              out_q <= mk_res(ST_OK, '0, '0, 1'b0);
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

[src/fixed_block_buffer_pool.sv]
// top level of the fixed block buffer pool: config registers, front and back
//
// Requests come in on the s_axis group: tuser[0] selects acquire (0) or
// release (1), tdata carries the address to release. Every request that
// no rebuild cuts off gives exactly one result on the m_axis group: tuser
// holds status and was_reserved, tdata the block address and block index.
// The config port writes enable, base address, block size and block count.
// Writing 1 to enable rebuilds the pool: a fill pass over all MAX_BLOCKS
// entries (256 as built) loads the free list memory and clears the
// reservation marks; no request is taken during that pass.
// An acquire takes the free list memory read, then the index times size
// multiply, then the base add; a release takes the one-bit-per-cycle
// divider and then the reservation mark read. One request is worked at a
// time: the back end takes no new request until the last result is taken.
// When the receiver stalls, the result is held, the back end waits and the
// front keeps taking requests until its two-entry queue has filled.
// After reset the pool is disabled and empty and every request answers
// status pool not enabled.
module fixed_block_buffer_pool import fbbp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [ADDR_W-1:0]    s_axis_tdata_i,   // [31:0] buffer_address
  input  logic [0:0]           s_axis_tuser_i,   // [0] action
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [39:0]          m_axis_tdata_o,   // [31:0] block_address, [39:32] block_index
  output logic [2:0]           m_axis_tuser_o    // [1:0] status, [2] was_reserved
);

  cfg_t    cfg_q;
  logic    rebuild;
  logic    fill_busy;
  logic    cmd_valid;
  logic    cmd_ready;
  cmd_t    cmd;
  result_t res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable <= 1'b0;
      cfg_q.base   <= ADDR_W'(4096);
      cfg_q.size   <= SIZE_W'(64);
      cfg_q.count  <= COUNT_W'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ENABLE: cfg_q.enable <= cfg_data_i[0];
        REG_BASE:   cfg_q.base   <= cfg_data_i;
        REG_SIZE:   cfg_q.size   <= cfg_data_i[SIZE_W-1:0];
        REG_COUNT:  cfg_q.count  <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // a write of 1 to enable rebuilds the pool
  assign rebuild = cfg_we_i && (cfg_index_i == REG_ENABLE) && cfg_data_i[0];

  fbbp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .fill_busy_i     (fill_busy),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_ready_i     (cmd_ready),
    .cmd_o           (cmd)
  );

  fbbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .rebuild_i   (rebuild),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .fill_busy_o (fill_busy),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  // result packing
  assign m_axis_tdata_o = {res.index, res.addr};
  assign m_axis_tuser_o = {res.was_reserved, res.status};

endmodule
